// ===== hw/rtl/mts_pkg.sv =====
// ----------------------------------------------------------------------------
// mts_pkg: shared types and constants of the min tracking stack
// Stack depth, count and address widths, operation and status codes.
// ----------------------------------------------------------------------------
package mts_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int VALUE_W     = 32;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 40;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [CNT_W-1:0]          count_type;
   typedef logic [ADDR_W-1:0]         addr_type;

   localparam value_type MINUS_ONE = '1;
   localparam count_type FULL_COUNT = CNT_W'(STACK_DEPTH);

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_MIN  = 2'd2,
      OP_NONE = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_type;

   typedef struct packed {
      logic       valid;
      value_type  value;
      status_type status;
   } result_type;

   typedef struct packed {
      logic      wr_en;
      addr_type  wr_addr;
      value_type wr_data;
      logic      rd_en;
      addr_type  rd_addr;
   } mem_req_type;

endpackage

// ===== hw/rtl/mts_ram.sv =====
// ----------------------------------------------------------------------------
// mts_ram: single-port-write, single-port-read synchronous memory
// Read data is registered, valid in the cycle after the read address.
// ----------------------------------------------------------------------------
module mts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/mts_ctrl.sv =====
// ----------------------------------------------------------------------------
// mts_ctrl: stack sequencer
// Reads both stack tops on accept, then updates counts and memories and
// forms the result in the following cycle.
// ----------------------------------------------------------------------------
module mts_ctrl
   import mts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  opcode_type  req_opcode,
   input  value_type   req_value,
   input  logic        out_free,
   output logic        req_ready,
   output mem_req_type val_mem,
   output mem_req_type min_mem,
   input  value_type   val_rd_data,
   input  value_type   min_rd_data,
   output result_type  result
);

   fsm_type    state_ff, state_in;
   opcode_type op_ff;
   value_type  value_ff;
   count_type  vcount_ff, vcount_in;
   count_type  mcount_ff, mcount_in;
   logic       accept;
   logic       exec;
   count_type  vtop;
   count_type  mtop;

   assign accept = req_valid && req_ready;
   assign exec   = (state_ff == FSM_EXEC);
   assign vtop   = vcount_ff - CNT_W'(1);
   assign mtop   = mcount_ff - CNT_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: state_in = FSM_IDLE;
         default:  state_in = FSM_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      unique case (state_ff)
         FSM_IDLE: req_ready = out_free;
         FSM_EXEC: req_ready = 1'b0;
         default:  req_ready = 1'b0;
      endcase
   end

   // operation on the fetched tops
   always_comb begin
      vcount_in       = vcount_ff;
      mcount_in       = mcount_ff;
      result.valid    = exec;
      result.value    = '0;
      result.status   = ST_OK;
      val_mem.wr_en   = 1'b0;
      val_mem.wr_addr = vcount_ff[ADDR_W-1:0];
      val_mem.wr_data = value_ff;
      val_mem.rd_en   = accept;
      val_mem.rd_addr = vtop[ADDR_W-1:0];
      min_mem.wr_en   = 1'b0;
      min_mem.wr_addr = mcount_ff[ADDR_W-1:0];
      min_mem.wr_data = value_ff;
      min_mem.rd_en   = accept;
      min_mem.rd_addr = mtop[ADDR_W-1:0];
      if (exec) begin
         case (op_ff)
            OP_PUSH: begin
               if (vcount_ff == FULL_COUNT) begin
                  result.status = ST_FULL;
               end else begin
                  val_mem.wr_en = 1'b1;
                  vcount_in     = vcount_ff + CNT_W'(1);
                  if ((mcount_ff == '0 || value_ff <= min_rd_data) &&
                      mcount_ff != FULL_COUNT) begin
                     min_mem.wr_en = 1'b1;
                     mcount_in     = mcount_ff + CNT_W'(1);
                  end
               end
            end
            OP_POP: begin
               if (vcount_ff == '0) begin
                  result.value  = MINUS_ONE;
                  result.status = ST_EMPTY;
               end else begin
                  result.value = val_rd_data;
                  vcount_in    = vtop;
                  if (mcount_ff != '0 && val_rd_data <= min_rd_data) begin
                     mcount_in = mtop;
                  end
               end
            end
            OP_MIN: begin
               if (vcount_ff == '0 || mcount_ff == '0) begin
                  result.value  = MINUS_ONE;
                  result.status = ST_EMPTY;
               end else begin
                  result.value = min_rd_data;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FSM_IDLE;
         vcount_ff <= '0;
         mcount_ff <= '0;
      end else begin
         state_ff  <= state_in;
         vcount_ff <= vcount_in;
         mcount_ff <= mcount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_opcode;
         value_ff <= req_value;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      vcount_ff <= FULL_COUNT && mcount_ff <= vcount_ff)
      else $error("stack counts out of range");

   a_exec_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> exec)
      else $error("accepted request not executed");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (exec && op_ff == OP_POP && vcount_ff != '0) |=>
         vcount_ff == $past(vtop))
      else $error("pop did not shrink value stack");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      !exec |-> !val_mem.wr_en && !min_mem.wr_en)
      else $error("memory write outside execute");
`endif

endmodule

// ===== hw/rtl/min_tracking_stack.sv =====
// ----------------------------------------------------------------------------
// min_tracking_stack: stack of signed 32-bit values with running minimum
// Main stack and minimum stack in two memories, registered result channel.
// ----------------------------------------------------------------------------
// Usage:
//   A request on req_ carries an opcode (push, pop, read minimum) and a push
//   value. Every request gives exactly one response on rsp_ with the popped
//   value or minimum and a status (ok, empty, full).
//   Each request is taken in the idle state, which reads both stack tops
//   from the memories, whose read data is registered; the execute state
//   then updates counts, writes back and loads the response register, and
//   no new request is taken before that. rsp_tvalid is registered.
//   Reset clears both stack counts at once; memory contents are not cleared
//   and need no startup pass, so requests are taken right after reset.
//   When the receiver holds rsp_tready low the response stays in its
//   register and req_tready stays low until it has been taken.
//   Stack depth is 64 entries; a push on a full stack is dropped.
// ----------------------------------------------------------------------------
module min_tracking_stack
   import mts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // opcode[1:0], push_value[33:2]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // result_value[31:0], status[33:32]
);

   mem_req_type val_mem;
   mem_req_type min_mem;
   value_type   val_rd_data;
   value_type   min_rd_data;
   result_type  result;
   logic        out_free;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   value_type   rsp_value_ff;
   status_type  rsp_status_ff;
   opcode_type  req_opcode;
   value_type   req_value;

   assign req_opcode = opcode_type'(req_tdata[1:0]);
   assign req_value  = value_type'(req_tdata[VALUE_W+1:2]);
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   mts_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_opcode  (req_opcode),
      .req_value   (req_value),
      .out_free    (out_free),
      .req_ready   (req_tready),
      .val_mem     (val_mem),
      .min_mem     (min_mem),
      .val_rd_data (val_rd_data),
      .min_rd_data (min_rd_data),
      .result      (result)
   );

   mts_ram #(.WIDTH(VALUE_W), .DEPTH(STACK_DEPTH)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_mem.wr_en),
      .wr_addr (val_mem.wr_addr),
      .wr_data (val_mem.wr_data),
      .rd_en   (val_mem.rd_en),
      .rd_addr (val_mem.rd_addr),
      .rd_data (val_rd_data)
   );

   mts_ram #(.WIDTH(VALUE_W), .DEPTH(STACK_DEPTH)) u_min_ram (
      .clock   (clock),
      .wr_en   (min_mem.wr_en),
      .wr_addr (min_mem.wr_addr),
      .wr_data (min_mem.wr_data),
      .rd_en   (min_mem.rd_en),
      .rd_addr (min_mem.rd_addr),
      .rd_data (min_rd_data)
   );

   // response register
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (result.valid) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_value_ff  <= result.value;
         rsp_status_ff <= result.status;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - VALUE_W - 2)'(0), rsp_status_ff, rsp_value_ff};

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> (!rsp_tvalid_ff || $past(rsp_tready)) || !rsp_tvalid_ff)
      else $error("response overwritten before taken");

   a_one_per_request: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> result.valid)
      else $error("request gave no response");

   a_ready_blocked: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request taken while response stalled");
`endif

endmodule
